>>> hdl/linear_interp_resampler_top_defines.svh
// assertion macros for the linear interpolation resampler
`ifndef LINEAR_INTERP_RESAMPLER_TOP_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LIR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lir assertion failed");
`define LIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lir assertion failed");
`else
`define LIR_ASSERT_SAME(lbl, ante, cons)
`define LIR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/lir_pkg.sv
// shared constants and types for the linear interpolation resampler
package lir_pkg;

    localparam int MAX_CHANNELS  = 8;
    localparam int SAMPLE_BITS   = 24;
    localparam int FRAC_BITS     = 16;
    localparam int POS_BITS      = 25;
    localparam int STEP_BITS     = 25;
    localparam int CNT_BITS      = 4;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 25;
    localparam int RUN_MAX       = 64;
    localparam int RUN_BITS      = $clog2(RUN_MAX);
    localparam int PROD_BITS     = SAMPLE_BITS + FRAC_BITS + 2;

    localparam logic [POS_BITS-1:0]    ONE_POS     = POS_BITS'(1) << FRAC_BITS;
    localparam logic [STEP_BITS-1:0]   STEP_MIN    = STEP_BITS'(ONE_POS >> 6);
    localparam logic [STEP_BITS-1:0]   STEP_MAX    = STEP_BITS'(ONE_POS << 8);
    localparam logic [STEP_BITS-1:0]   STEP_RESET  = STEP_BITS'(ONE_POS);
    localparam logic [CNT_BITS-1:0]    CHAN_RESET  = CNT_BITS'(2);
    localparam logic [CNT_BITS-1:0]    CHAN_MIN    = CNT_BITS'(1);
    localparam logic [CNT_BITS-1:0]    CHAN_MAX    = CNT_BITS'(MAX_CHANNELS);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_BIAS = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [RUN_BITS-1:0]    RUN_LAST    = RUN_BITS'(RUN_MAX - 1);
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(1) << (FRAC_BITS - 1);

    localparam logic [CFG_IDX_BITS-1:0] REG_STEP          = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = CFG_IDX_BITS'(1);

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic prime;
        logic skip;
        logic take;
        logic mul;
        logic load_out;
        logic finish;
    } lir_cmd_t;

    typedef struct packed {
        logic primed;
        logic pos_ahead;
        logic run_last;
    } lir_status_t;

endpackage

>>> hdl/lir_datapath.sv
// frame store, read position, per-lane blend arithmetic and output register
module lir_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lir_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [lir_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  lir_pkg::sample_t                    in_frame [lir_pkg::MAX_CHANNELS],
    input  lir_pkg::lir_cmd_t                   cmd,
    output lir_pkg::lir_status_t                status,
    output lir_pkg::sample_t                    out_frame [lir_pkg::MAX_CHANNELS],
    output logic                                last_of_run
);

    logic [lir_pkg::STEP_BITS-1:0] step_cfg_reg;
    logic [lir_pkg::CNT_BITS-1:0]  chan_cfg_reg;

    logic                          primed_reg;
    logic                          primed_next;
    logic [lir_pkg::POS_BITS-1:0]  pos_reg;
    logic [lir_pkg::POS_BITS-1:0]  pos_next;
    logic [lir_pkg::RUN_BITS-1:0]  cnt_reg;
    logic [lir_pkg::RUN_BITS-1:0]  cnt_next;
    logic                          run_last_reg;
    logic                          run_last_next;

    lir_pkg::sample_t              prev_reg [lir_pkg::MAX_CHANNELS];
    lir_pkg::sample_t              cur_reg  [lir_pkg::MAX_CHANNELS];
    lir_pkg::sample_t              in_biased [lir_pkg::MAX_CHANNELS];
    logic [lir_pkg::STEP_BITS-1:0] step_use_reg;
    logic [lir_pkg::STEP_BITS-1:0] step_clamped;
    logic [lir_pkg::CNT_BITS-1:0]  lanes_clamped;
    logic [lir_pkg::MAX_CHANNELS-1:0] mask_reg;
    logic [lir_pkg::MAX_CHANNELS-1:0] mask_next;

    logic signed [lir_pkg::PROD_BITS-1:0] prod_reg  [lir_pkg::MAX_CHANNELS];
    logic signed [lir_pkg::PROD_BITS-1:0] prod_next [lir_pkg::MAX_CHANNELS];
    logic signed [lir_pkg::SAMPLE_BITS:0] diff [lir_pkg::MAX_CHANNELS];
    logic signed [lir_pkg::FRAC_BITS:0]   frac;
    logic signed [lir_pkg::PROD_BITS-1:0] acc [lir_pkg::MAX_CHANNELS];
    lir_pkg::sample_t                     blend [lir_pkg::MAX_CHANNELS];

    lir_pkg::sample_t              out_reg [lir_pkg::MAX_CHANNELS];
    logic                          last_out_reg;
    logic [lir_pkg::POS_BITS-1:0]  pos_sum;
    logic                          last_now;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg <= lir_pkg::STEP_RESET;
            chan_cfg_reg <= lir_pkg::CHAN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lir_pkg::REG_STEP:
                begin
                    step_cfg_reg <= cfg_data[lir_pkg::STEP_BITS-1:0];
                end
                lir_pkg::REG_CHANNEL_COUNT:
                begin
                    chan_cfg_reg <= cfg_data[lir_pkg::CNT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (step_cfg_reg < lir_pkg::STEP_MIN)
            step_clamped = lir_pkg::STEP_MIN;
        else if (step_cfg_reg > lir_pkg::STEP_MAX)
            step_clamped = lir_pkg::STEP_MAX;
        else
            step_clamped = step_cfg_reg;

        if (chan_cfg_reg < lir_pkg::CHAN_MIN)
            lanes_clamped = lir_pkg::CHAN_MIN;
        else if (chan_cfg_reg > lir_pkg::CHAN_MAX)
            lanes_clamped = lir_pkg::CHAN_MAX;
        else
            lanes_clamped = chan_cfg_reg;

        for (int i = 0; i < lir_pkg::MAX_CHANNELS; i++)
        begin
            mask_next[i] = lir_pkg::CNT_BITS'(i) < lanes_clamped;
            // offset-binary form: flip the sign bit
            in_biased[i] = in_frame[i] ^ lir_pkg::SAMPLE_BIAS;
        end
    end

    // position update and end-of-run detection
    always_comb
    begin
        pos_sum  = pos_reg + step_use_reg;
        last_now = (pos_sum >= lir_pkg::ONE_POS) || (cnt_reg == lir_pkg::RUN_LAST);

        primed_next   = primed_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        run_last_next = run_last_reg;

        if (cmd.prime)
            primed_next = 1'b1;
        if (cmd.skip)
            pos_next = pos_reg - lir_pkg::ONE_POS;
        if (cmd.take)
            cnt_next = '0;
        if (cmd.mul)
        begin
            pos_next      = last_now ? (pos_sum - lir_pkg::ONE_POS) : pos_sum;
            cnt_next      = cnt_reg + 1'b1;
            run_last_next = last_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg   <= 1'b0;
            pos_reg      <= '0;
            cnt_reg      <= '0;
            run_last_reg <= 1'b0;
        end
        else
        begin
            primed_reg   <= primed_next;
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            run_last_reg <= run_last_next;
        end
    end

    // previous frame store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lir_pkg::MAX_CHANNELS; i++)
                prev_reg[i] <= lir_pkg::SAMPLE_BIAS;
        end
        else if (cmd.prime || cmd.skip)
        begin
            for (int i = 0; i < lir_pkg::MAX_CHANNELS; i++)
                prev_reg[i] <= in_biased[i];
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < lir_pkg::MAX_CHANNELS; i++)
                prev_reg[i] <= cur_reg[i];
        end
    end

    // blend: prev*(1-f) + cur*f = (prev << frac) + (cur - prev)*f
    always_comb
    begin
        frac = signed'({1'b0, pos_reg[lir_pkg::FRAC_BITS-1:0]});
        for (int i = 0; i < lir_pkg::MAX_CHANNELS; i++)
        begin
            diff[i] = signed'({1'b0, cur_reg[i]}) - signed'({1'b0, prev_reg[i]});
            prod_next[i] = diff[i] * frac;
            acc[i] = signed'({2'b00, prev_reg[i], lir_pkg::FRAC_BITS'(0)})
                     + prod_reg[i] + lir_pkg::ROUND_HALF;
            blend[i] = acc[i][lir_pkg::FRAC_BITS +: lir_pkg::SAMPLE_BITS]
                       ^ lir_pkg::SAMPLE_BIAS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            for (int i = 0; i < lir_pkg::MAX_CHANNELS; i++)
                cur_reg[i] <= in_biased[i];
            step_use_reg <= step_clamped;
            mask_reg     <= mask_next;
        end
        if (cmd.mul)
        begin
            for (int i = 0; i < lir_pkg::MAX_CHANNELS; i++)
                prod_reg[i] <= prod_next[i];
        end
        if (cmd.load_out)
        begin
            for (int i = 0; i < lir_pkg::MAX_CHANNELS; i++)
                out_reg[i] <= mask_reg[i] ? blend[i] : '0;
            last_out_reg <= run_last_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < lir_pkg::MAX_CHANNELS; i++)
            out_frame[i] = out_reg[i];
    end

    assign last_of_run      = last_out_reg;
    assign status.primed    = primed_reg;
    assign status.pos_ahead = pos_reg >= lir_pkg::ONE_POS;
    assign status.run_last  = run_last_reg;

endmodule

>>> hdl/lir_ctrl.sv
// sequencer for the resampler: accept, multiply, sum and output handshake
module lir_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  lir_pkg::lir_status_t status,
    output lir_pkg::lir_cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_SUM  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   in_take;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    // output register can be loaded when empty or being emptied this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (!status.primed)
                        cmd.prime = 1'b1;
                    else if (status.pos_ahead)
                        cmd.skip = 1'b1;
                    else
                    begin
                        cmd.take   = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.run_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hdl/linear_interp_resampler_top.sv
// linear interpolation resampler top level
//
//  channel | direction | handshake            | payload
//  input   | in        | in_valid / in_stall  | in_0 .. in_7
//  output  | out       | out_valid / out_stall| out_0 .. out_7, last_of_run
//  config  | in        | cfg_we               | cfg_index, cfg_data
//
// each output frame goes through the lane multipliers into the product register, then through
// the rounding adders into the output register; a run of up to 64 frames holds the input
// stalled for the whole run, and longer while out_stall is high.
// the priming frame and a frame that lands past the position are taken while idle and give no output.
// reset clears position, run count, primed flag, previous frames and the output valid at once.
// a held output stalls a run in progress and so the input; while idle a new input item is still taken.
`include "linear_interp_resampler_top_defines.svh"

module linear_interp_resampler_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lir_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [lir_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] in_0,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] in_1,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] in_2,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] in_3,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] in_4,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] in_5,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] in_6,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] in_7,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] out_0,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] out_1,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] out_2,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] out_3,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] out_4,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] out_5,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] out_6,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] out_7,
    output logic                              last_of_run
);

    lir_pkg::sample_t     in_frame  [lir_pkg::MAX_CHANNELS];
    lir_pkg::sample_t     out_frame [lir_pkg::MAX_CHANNELS];
    lir_pkg::lir_cmd_t    cmd;
    lir_pkg::lir_status_t status;

    assign in_frame[0] = in_0;
    assign in_frame[1] = in_1;
    assign in_frame[2] = in_2;
    assign in_frame[3] = in_3;
    assign in_frame[4] = in_4;
    assign in_frame[5] = in_5;
    assign in_frame[6] = in_6;
    assign in_frame[7] = in_7;

    assign out_0 = out_frame[0];
    assign out_1 = out_frame[1];
    assign out_2 = out_frame[2];
    assign out_3 = out_frame[3];
    assign out_4 = out_frame[4];
    assign out_5 = out_frame[5];
    assign out_6 = out_frame[6];
    assign out_7 = out_frame[7];

    lir_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lir_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_frame    (in_frame),
        .cmd         (cmd),
        .status      (status),
        .out_frame   (out_frame),
        .last_of_run (last_of_run)
    );

    // a run step always starts with the position below one
    `LIR_ASSERT_SAME(a_mul_pos_in_range, cmd.mul, !status.pos_ahead)
    // never overwrite a result that is still waiting
    `LIR_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid || !out_stall)
    // mid-run results keep the input side closed
    `LIR_ASSERT_NEXT(a_run_holds_input, cmd.load_out && !status.run_last, in_stall)

endmodule
